### rtl/core/lpbs_pkg.sv
// Shared types and constants for the loop point boundary search block.
// No dependencies; imported by lpbs_track and loop_point_boundary_search.
`timescale 1ns / 1ps

package lpbs_pkg;

   // Field and register widths
   localparam int CFG_W       = 24;
   localparam int SAMPLE_W    = 16;
   localparam int SCORE_W     = 17;
   localparam int BOUND_W     = CFG_W + 1;
   localparam int CSR_INDEX_W = 3;

   localparam int FRAME_INDEX_BITS_DEFAULT = 24;

   // Score value meaning "no point scored yet"
   localparam logic [SCORE_W-1:0] SCORE_NONE   = '1;
   localparam logic [CFG_W-1:0]   RADIUS_RESET = CFG_W'(2048);

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_START_FRAME     = 3'd0,
      CFG_END_FRAME       = 3'd1,
      CFG_LOOP_START_HINT = 3'd2,
      CFG_LOOP_END_HINT   = 3'd3,
      CFG_SEARCH_RADIUS   = 3'd4
   } cfg_index_type;

   // Input transaction payload
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic             found;
      logic [CFG_W-1:0] splice_start;
      logic [CFG_W-1:0] splice_end;
   } rsp_type;

   // Per-sample control into a window tracker
   typedef struct packed {
      logic step;    // scoring stage advances with a sample
      logic scored;  // range valid and frame >= 1
      logic last;    // sample closes the pass
   } trk_ctl_type;

endpackage

### rtl/core/loop_point_boundary_search.sv
// Top level of the loop point boundary search block.
// Depends on lpbs_pkg and lpbs_track.
`timescale 1ns / 1ps

// Streams PCM samples (frame 0 first) and, on the sample marked last, returns one
// result with the quietest splice points near the loop start and loop end hints.
// One sample is accepted every cycle unless the input stalls; the last sample of a
// pass reaches rsp through the capture, score/clamp, window, compare/update,
// finalize and result stages. Input stalls only when a closing sample reaches the
// compare stage while the result register and the finalize register both hold
// unread results. Configuration writes are taken at once (csr_ready is always high)
// and must be issued with the pipeline empty.

module loop_point_boundary_search
   import lpbs_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   localparam int CMP_W = (FRAME_INDEX_BITS > BOUND_W) ? FRAME_INDEX_BITS : BOUND_W;
   localparam int FW    = FRAME_INDEX_BITS;

   // Window low bound: max(c - r, start + 1), start + 1 when c <= r
   function automatic logic [BOUND_W-1:0] win_lo(input logic [CFG_W-1:0] c,
                                                 input logic [CFG_W-1:0] r,
                                                 input logic [CFG_W-1:0] st);
      logic [BOUND_W-1:0] st_p1;
      logic [BOUND_W-1:0] lo;
      st_p1 = BOUND_W'(st) + BOUND_W'(1);
      lo    = (c > r) ? BOUND_W'(c - r) : st_p1;
      if (lo < st_p1) begin
         lo = st_p1;
      end
      return lo;
   endfunction

   // Window high bound: min(c + r, end - 1), no wrap
   function automatic logic [BOUND_W-1:0] win_hi(input logic [CFG_W-1:0] c,
                                                 input logic [CFG_W-1:0] r,
                                                 input logic [CFG_W-1:0] en);
      logic [BOUND_W-1:0] hi;
      hi = BOUND_W'(c) + BOUND_W'(r);
      if (hi >= BOUND_W'(en)) begin
         hi = BOUND_W'(en) - BOUND_W'(1);
      end
      return hi;
   endfunction

   // Configuration registers
   logic [CFG_W-1:0] start_frame_ff;
   logic [CFG_W-1:0] end_frame_ff;
   logic [CFG_W-1:0] loop_start_hint_ff;
   logic [CFG_W-1:0] loop_end_hint_ff;
   logic [CFG_W-1:0] search_radius_ff;

   // Stream state
   logic [FW-1:0]              frame_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;

   // Stage 1: raw sample pair
   logic                       s1_valid_ff;
   logic                       s1_last_ff;
   logic [FW-1:0]              s1_frame_ff;
   logic signed [SAMPLE_W-1:0] s1_cur_ff;
   logic signed [SAMPLE_W-1:0] s1_prev_ff;

   // Stage 2: score and clamped hints
   logic                s2_valid_ff;
   logic                s2_last_ff;
   logic                s2_scored_ff;
   logic                s2_range_ok_ff;
   logic [FW-1:0]       s2_frame_ff;
   logic [SCORE_W-1:0]  s2_score_ff;
   logic [CFG_W-1:0]    s2_ls_ff;
   logic [CFG_W-1:0]    s2_le_ff;

   // Stage 3: window bounds
   logic                s3_valid_ff;
   logic                s3_last_ff;
   logic                s3_scored_ff;
   logic                s3_range_ok_ff;
   logic [FW-1:0]       s3_frame_ff;
   logic [SCORE_W-1:0]  s3_score_ff;
   logic [CFG_W-1:0]    s3_ls_ff;
   logic [CFG_W-1:0]    s3_le_ff;
   logic [BOUND_W-1:0]  s3_slo_ff;
   logic [BOUND_W-1:0]  s3_shi_ff;
   logic [BOUND_W-1:0]  s3_elo_ff;
   logic [BOUND_W-1:0]  s3_ehi_ff;

   // Stage 4: closing values of a pass
   logic                f4_valid_ff;
   logic                f4_range_ok_ff;
   logic [CFG_W-1:0]    f4_ls_ff;
   logic [CFG_W-1:0]    f4_le_ff;
   logic [SCORE_W-1:0]  f4_sscore_ff;
   logic [FW-1:0]       f4_sframe_ff;
   logic [SCORE_W-1:0]  f4_escore_ff;
   logic [FW-1:0]       f4_eframe_ff;

   // Result register
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   logic                pipe_en;
   logic                req_accept;
   logic                f4_move;
   logic                f4_free;
   logic                f4_load;

   logic [SAMPLE_W-1:0] abs_a;
   logic [SAMPLE_W-1:0] abs_b;
   logic [SCORE_W-1:0]  score_sum;
   logic [SCORE_W-1:0]  score_in;
   logic                range_ok_in;
   logic [CFG_W-1:0]    ls_in;
   logic [CFG_W-1:0]    le_in;

   trk_ctl_type         trk_ctl;
   logic [SCORE_W-1:0]  s_best_score;
   logic [FW-1:0]       s_best_frame;
   logic [SCORE_W-1:0]  e_best_score;
   logic [FW-1:0]       e_best_frame;

   logic [CMP_W-1:0]    fin_ls;
   logic [CMP_W-1:0]    fin_le;
   logic [CMP_W:0]      fin_ls_p1;

   // Flow control: only a closing sample with nowhere to go holds the pipe
   assign f4_move    = f4_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign f4_free    = !f4_valid_ff || f4_move;
   assign pipe_en    = !(s3_valid_ff && s3_last_ff && !f4_free);
   assign f4_load    = pipe_en && s3_valid_ff && s3_last_ff;
   assign req_ready  = pipe_en;
   assign req_accept = req_valid && pipe_en;
   assign csr_ready  = 1'b1;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_frame_ff     <= '0;
         end_frame_ff       <= '0;
         loop_start_hint_ff <= '0;
         loop_end_hint_ff   <= '0;
         search_radius_ff   <= RADIUS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CFG_START_FRAME:     start_frame_ff     <= csr_data;
            CFG_END_FRAME:       end_frame_ff       <= csr_data;
            CFG_LOOP_START_HINT: loop_start_hint_ff <= csr_data;
            CFG_LOOP_END_HINT:   loop_end_hint_ff   <= csr_data;
            CFG_SEARCH_RADIUS:   search_radius_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Frame counter and previous sample; a closing sample restarts the pass
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         prev_ff  <= '0;
      end else if (req_accept) begin
         if (req_data.last) begin
            frame_ff <= '0;
            prev_ff  <= '0;
         end else begin
            frame_ff <= frame_ff + FW'(1);
            prev_ff  <= req_data.sample;
         end
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_last_ff  <= req_data.last;
         s1_frame_ff <= frame_ff;
         s1_cur_ff   <= req_data.sample;
         s1_prev_ff  <= prev_ff;
      end
   end

   // Score, range check and hint clamping
   always_comb begin
      abs_a     = s1_prev_ff[SAMPLE_W-1] ? SAMPLE_W'(-s1_prev_ff) : SAMPLE_W'(s1_prev_ff);
      abs_b     = s1_cur_ff[SAMPLE_W-1]  ? SAMPLE_W'(-s1_cur_ff)  : SAMPLE_W'(s1_cur_ff);
      score_sum = SCORE_W'(abs_a) + SCORE_W'(abs_b);
      score_in  = (s1_prev_ff[SAMPLE_W-1] != s1_cur_ff[SAMPLE_W-1]) ?
                  (score_sum >> 1) : score_sum;

      range_ok_in = BOUND_W'(end_frame_ff) > (BOUND_W'(start_frame_ff) + BOUND_W'(1));

      ls_in = loop_start_hint_ff;
      if ((ls_in < start_frame_ff) || (ls_in >= end_frame_ff)) begin
         ls_in = start_frame_ff;
      end
      le_in = loop_end_hint_ff;
      if ((le_in <= ls_in) || (le_in > end_frame_ff)) begin
         le_in = end_frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_last_ff     <= s1_last_ff;
         s2_scored_ff   <= range_ok_in && (s1_frame_ff != '0);
         s2_range_ok_ff <= range_ok_in;
         s2_frame_ff    <= s1_frame_ff;
         s2_score_ff    <= score_in;
         s2_ls_ff       <= ls_in;
         s2_le_ff       <= le_in;
      end
   end

   // Window bounds around both clamped hints
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_last_ff     <= s2_last_ff;
         s3_scored_ff   <= s2_scored_ff;
         s3_range_ok_ff <= s2_range_ok_ff;
         s3_frame_ff    <= s2_frame_ff;
         s3_score_ff    <= s2_score_ff;
         s3_ls_ff       <= s2_ls_ff;
         s3_le_ff       <= s2_le_ff;
         s3_slo_ff      <= win_lo(s2_ls_ff, search_radius_ff, start_frame_ff);
         s3_shi_ff      <= win_hi(s2_ls_ff, search_radius_ff, end_frame_ff);
         s3_elo_ff      <= win_lo(s2_le_ff, search_radius_ff, start_frame_ff);
         s3_ehi_ff      <= win_hi(s2_le_ff, search_radius_ff, end_frame_ff);
      end
   end

   // Compare and update, one tracker per window
   assign trk_ctl.step   = pipe_en && s3_valid_ff;
   assign trk_ctl.scored = s3_scored_ff;
   assign trk_ctl.last   = s3_last_ff;

   lpbs_track #(
      .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
   ) u_start_track (
      .clock        (clock),
      .reset        (reset),
      .ctl          (trk_ctl),
      .frame        (s3_frame_ff),
      .score        (s3_score_ff),
      .win_lo       (s3_slo_ff),
      .win_hi       (s3_shi_ff),
      .lowest_score (s_best_score),
      .best_frame   (s_best_frame)
   );

   lpbs_track #(
      .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
   ) u_end_track (
      .clock        (clock),
      .reset        (reset),
      .ctl          (trk_ctl),
      .frame        (s3_frame_ff),
      .score        (s3_score_ff),
      .win_lo       (s3_elo_ff),
      .win_hi       (s3_ehi_ff),
      .lowest_score (e_best_score),
      .best_frame   (e_best_frame)
   );

   // Capture the closing values of a pass
   always_ff @(posedge clock) begin
      if (reset) begin
         f4_valid_ff <= 1'b0;
      end else if (f4_load) begin
         f4_valid_ff <= 1'b1;
      end else if (f4_move) begin
         f4_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (f4_load) begin
         f4_range_ok_ff <= s3_range_ok_ff;
         f4_ls_ff       <= s3_ls_ff;
         f4_le_ff       <= s3_le_ff;
         f4_sscore_ff   <= s_best_score;
         f4_sframe_ff   <= s_best_frame;
         f4_escore_ff   <= e_best_score;
         f4_eframe_ff   <= e_best_frame;
      end
   end

   // Pick found points or hints, then keep loop end above loop start
   always_comb begin
      fin_ls = (f4_sscore_ff != SCORE_NONE) ? CMP_W'(f4_sframe_ff) : CMP_W'(f4_ls_ff);
      fin_le = (f4_escore_ff != SCORE_NONE) ? CMP_W'(f4_eframe_ff) : CMP_W'(f4_le_ff);
      fin_ls_p1 = (CMP_W + 1)'(fin_ls) + (CMP_W + 1)'(1);
      if ((CMP_W + 1)'(fin_le) <= fin_ls_p1) begin
         fin_le = (fin_ls_p1 < (CMP_W + 1)'(end_frame_ff)) ?
                  fin_ls_p1[CMP_W-1:0] : CMP_W'(end_frame_ff);
      end

      rsp_data_in.found = f4_range_ok_ff;
      if (f4_range_ok_ff) begin
         rsp_data_in.splice_start = fin_ls[CFG_W-1:0];
         rsp_data_in.splice_end   = fin_le[CFG_W-1:0];
      end else begin
         rsp_data_in.splice_start = '0;
         rsp_data_in.splice_end   = '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (f4_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (f4_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/lpbs_track.sv
// Best splice point tracker for one search window.
// Depends on lpbs_pkg.
`timescale 1ns / 1ps

module lpbs_track
   import lpbs_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  trk_ctl_type                 ctl,
   input  logic [FRAME_INDEX_BITS-1:0] frame,
   input  logic [SCORE_W-1:0]          score,
   input  logic [BOUND_W-1:0]          win_lo,
   input  logic [BOUND_W-1:0]          win_hi,
   output logic [SCORE_W-1:0]          lowest_score,
   output logic [FRAME_INDEX_BITS-1:0] best_frame
);

   localparam int CMP_W = (FRAME_INDEX_BITS > BOUND_W) ? FRAME_INDEX_BITS : BOUND_W;

   logic [SCORE_W-1:0]          best_score_ff;
   logic [SCORE_W-1:0]          best_score_in;
   logic [FRAME_INDEX_BITS-1:0] best_frame_ff;
   logic [FRAME_INDEX_BITS-1:0] best_frame_in;
   logic                        hit;

   // First strictly smaller score inside the window wins
   always_comb begin
      hit = ctl.scored
            && (CMP_W'(frame) >= CMP_W'(win_lo))
            && (CMP_W'(frame) <= CMP_W'(win_hi))
            && (score < best_score_ff);
      best_score_in = hit ? score : best_score_ff;
      best_frame_in = hit ? frame : best_frame_ff;
   end

   // Post-update value goes out; a closing sample restarts the search
   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= SCORE_NONE;
      end else if (ctl.step) begin
         best_score_ff <= ctl.last ? SCORE_NONE : best_score_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         best_frame_ff <= best_frame_in;
      end
   end

   assign lowest_score = best_score_in;
   assign best_frame   = best_frame_in;

endmodule

### tb/tb_loop_point_boundary_search.sv
// Self-checking testbench for loop_point_boundary_search: directed and random sample passes.
// Depends on lpbs_pkg and the block's RTL; the expected splice points are computed locally.
`timescale 1ns / 1ps

module tb_loop_point_boundary_search;
   import lpbs_pkg::*;

   localparam int FRAME_BITS   = FRAME_INDEX_BITS_DEFAULT;
   localparam int LATENCY      = 4;
   localparam int SETTLE       = 3 * LATENCY;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [CFG_W-1:0]       CFG_MAX            = '1;
   localparam logic [CSR_INDEX_W-1:0] CFG_FIRST_UNMAPPED =
      CSR_INDEX_W'(CFG_SEARCH_RADIUS + 1);

   // Shapes of sample content within one pass
   typedef enum int {SHAPE_FULL, SHAPE_QUIET, SHAPE_EXTREME} shape_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data  = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int errors        = 0;
   int samples_sent  = 0;
   int results_seen  = 0;
   int reg_writes    = 0;

   // Local copy of the registers and the pass state
   logic [CFG_W-1:0]           reg_start_frame, reg_end_frame;
   logic [CFG_W-1:0]           reg_start_hint, reg_end_hint, reg_radius;
   logic [FRAME_BITS-1:0]      frames_seen;
   logic signed [SAMPLE_W-1:0] prior_sample;
   logic [SCORE_W-1:0]         head_score, tail_score;
   logic [CFG_W-1:0]           head_frame, tail_frame;
   rsp_type                    expected_points[$];

   loop_point_boundary_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      errors++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic bit range_open();
      return longint'(reg_end_frame) > longint'(reg_start_frame) + 1;
   endfunction

   // Hints outside the range fall back to the range edges
   function automatic void clamp_hints(output longint hs, output longint he);
      longint st = reg_start_frame;
      longint en = reg_end_frame;
      hs = reg_start_hint;
      he = reg_end_hint;
      if (hs < st || hs >= en) hs = st;
      if (he <= hs || he > en) he = en;
   endfunction

   // Score one point against the window around a centre; first strict minimum wins
   function automatic void track_point(input longint centre, input longint f,
                                       input logic [SCORE_W-1:0] score,
                                       inout logic [SCORE_W-1:0] lowest_score,
                                       inout logic [CFG_W-1:0] best_frame);
      longint st  = reg_start_frame;
      longint en  = reg_end_frame;
      longint rad = reg_radius;
      longint lo, hi;
      lo = (centre > rad) ? centre - rad : st + 1;
      hi = centre + rad;
      if (lo < st + 1) lo = st + 1;
      if (hi >= en) hi = en - 1;
      if (f >= lo && f <= hi && score < lowest_score) begin
         lowest_score = score;
         best_frame   = CFG_W'(f);
      end
   endfunction

   function automatic void clear_pass();
      frames_seen  = '0;
      prior_sample = '0;
      head_score   = SCORE_NONE;
      tail_score   = SCORE_NONE;
      head_frame   = '0;
      tail_frame   = '0;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
      case (idx)
         CFG_START_FRAME:     reg_start_frame = data;
         CFG_END_FRAME:       reg_end_frame   = data;
         CFG_LOOP_START_HINT: reg_start_hint  = data;
         CFG_LOOP_END_HINT:   reg_end_hint    = data;
         CFG_SEARCH_RADIUS:   reg_radius      = data;
         default: ;
      endcase
   endfunction

   // Advance the pass by one accepted sample; queue the splice points on the closing one
   function automatic void splice_predict(input req_type item);
      longint  f  = frames_seen;
      longint  en = reg_end_frame;
      int      a  = prior_sample;
      int      b  = $signed(item.sample);
      int      score;
      longint  hs, he;
      rsp_type res;
      if (range_open() && f >= 1) begin
         score = (a < 0 ? -a : a) + (b < 0 ? -b : b);
         if ((a < 0) != (b < 0)) score = score >> 1;
         clamp_hints(hs, he);
         track_point(hs, f, SCORE_W'(score), head_score, head_frame);
         track_point(he, f, SCORE_W'(score), tail_score, tail_frame);
      end
      prior_sample = item.sample;
      frames_seen  = frames_seen + 1'b1;
      if (item.last) begin
         res = '0;
         if (range_open()) begin
            clamp_hints(hs, he);
            if (head_score != SCORE_NONE) hs = head_frame;
            if (tail_score != SCORE_NONE) he = tail_frame;
            // keep the end strictly past start
            if (he <= hs + 1) he = (hs + 1 < en) ? hs + 1 : en;
            res.found        = 1'b1;
            res.splice_start = CFG_W'(hs);
            res.splice_end   = CFG_W'(he);
         end
         expected_points.push_back(res);
         clear_pass();
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      reg_writes++;
   endtask

   task automatic write_config(input logic [CFG_W-1:0] s, e, lsh, leh, rad);
      write_reg(CFG_START_FRAME, s);
      write_reg(CFG_END_FRAME, e);
      write_reg(CFG_LOOP_START_HINT, lsh);
      write_reg(CFG_LOOP_END_HINT, leh);
      write_reg(CFG_SEARCH_RADIUS, rad);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
      int      gap = 0;
      req_type item;
      item.sample = value;
      item.last   = is_last;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      splice_predict(item);
      samples_sent++;
   endtask

   // Drop valid, wait for every pending result, then let the pipeline settle
   task automatic wait_for_results();
      int waited = 0;
      req_valid <= 1'b0;
      while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (expected_points.size() != 0) begin
         report_mismatch("pending results never returned", expected_points.size(), 0);
         expected_points.delete();
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input shape_type shape);
      case (shape)
         SHAPE_FULL:  return SAMPLE_W'($urandom());
         SHAPE_QUIET: return SAMPLE_W'($urandom_range(8) - 4);
         default: begin
            case ($urandom_range(4))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               2:       return 16'hFFFF;
               3:       return 16'h0001;
               default: return 16'h0000;
            endcase
         end
      endcase
   endfunction

   task automatic send_pass(input int len, input shape_type shape);
      for (int i = 0; i < len; i++) send_sample(pick_sample(shape), i == len - 1);
   endtask

   // ---------------------------------------------------------------- tests

   // Registers at reset: empty range, so the pass closes with nothing found
   task automatic test_reset_defaults();
      send_sample(SAMPLE_W'($urandom()), 1'b1);
      wait_for_results();
   endtask

   // Unmapped indexes must not disturb anything; radius keeps its reset value
   task automatic test_unknown_index();
      logic [SAMPLE_W-1:0] extremes[8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                           16'h0001, 16'h8000, 16'h7FFF, 16'h0000};
      for (int k = CFG_FIRST_UNMAPPED; k < 2 ** CSR_INDEX_W; k++)
         write_reg(CSR_INDEX_W'(k), CFG_MAX);
      write_reg(CFG_START_FRAME, '0);
      write_reg(CFG_END_FRAME, CFG_W'(8));
      write_reg(CFG_LOOP_START_HINT, CFG_W'(2));
      write_reg(CFG_LOOP_END_HINT, CFG_W'(6));
      csr_valid <= 1'b0;
      for (int i = 0; i < 8; i++) send_sample(extremes[i], i == 7);
      wait_for_results();
   endtask

   // Range at the top of the frame space: windows beyond the delivered frames
   task automatic test_top_of_range();
      write_config(CFG_W'(CFG_MAX - 2), CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
      send_pass(2, SHAPE_FULL);
      wait_for_results();
      write_config(CFG_W'(CFG_MAX - 1), CFG_MAX, '0, '0, '0);
      send_pass(1, SHAPE_FULL);
      wait_for_results();
   endtask

   // Zero radius: one-point and empty windows, then the end is pushed to the range end
   task automatic test_radius_zero_windows();
      write_config(CFG_W'(2), CFG_W'(6), CFG_W'(5), CFG_W'(6), '0);
      for (int i = 0; i < 6; i++) send_sample(16'd7, i == 5);
      wait_for_results();
   endtask

   // Equal scores everywhere: the earliest point wins and the end is moved past it
   task automatic test_first_minimum_ties();
      write_config('0, CFG_W'(5), CFG_W'(1), CFG_W'(3), CFG_W'(4));
      for (int i = 0; i < 5; i++) send_sample(-16'sd300, i == 4);
      wait_for_results();
   endtask

   // Receiver holds off while single-sample passes keep coming, so the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_config('0, CFG_W'(4), CFG_W'(1), CFG_W'(2), CFG_W'(1));
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 16; i++) send_sample(SAMPLE_W'($urandom()), 1'b1);
      wait_for_results();
   endtask

   task automatic random_config();
      logic [CFG_W-1:0] s, e, lsh, leh, rad;
      int unsigned pick = $urandom_range(9);
      if (pick == 0) begin
         s   = CFG_W'($urandom());
         e   = CFG_W'($urandom());
         lsh = CFG_W'($urandom());
         leh = CFG_W'($urandom());
         rad = CFG_W'($urandom());
      end else if (pick == 1) begin
         s   = CFG_MAX - CFG_W'($urandom_range(3));
         e   = CFG_MAX - CFG_W'($urandom_range(2));
         lsh = CFG_MAX - CFG_W'($urandom_range(4));
         leh = CFG_MAX - CFG_W'($urandom_range(4));
         rad = $urandom_range(1) ? CFG_MAX : CFG_W'($urandom_range(3));
      end else begin
         s   = CFG_W'($urandom_range(12));
         e   = s + CFG_W'($urandom_range(40));
         lsh = CFG_W'($urandom_range(e + 4));
         leh = CFG_W'($urandom_range(e + 4));
         case ($urandom_range(5))
            0:       rad = '0;
            1:       rad = CFG_MAX;
            2:       rad = CFG_W'($urandom());
            default: rad = CFG_W'($urandom_range(12));
         endcase
      end
      write_config(s, e, lsh, leh, rad);
   endtask

   // Random settings, each followed by a few passes of random length and content
   task automatic test_random_passes(input int send_pct, input int recv_pct, input int items);
      int target = samples_sent + items;
      int len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (samples_sent < target) begin
         wait_for_results();
         random_config();
         repeat ($urandom_range(1, 4)) begin
            len = (reg_end_frame < 64) ? $urandom_range(1, reg_end_frame + 4)
                                       : $urandom_range(1, 40);
            send_pass(len, shape_type'($urandom_range(2)));
         end
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------- receiver and checker

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_points.size() == 0) begin
            report_mismatch("result transaction with none pending", 0, rsp_data);
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", want.found, rsp_data.found);
            if (rsp_data.splice_start !== want.splice_start)
               report_mismatch("splice_start", want.splice_start, rsp_data.splice_start);
            if (rsp_data.splice_end !== want.splice_end)
               report_mismatch("splice_end", want.splice_end, rsp_data.splice_end);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reg_start_frame = '0;
      reg_end_frame   = '0;
      reg_start_hint  = '0;
      reg_end_hint    = '0;
      reg_radius      = RADIUS_RESET;
      clear_pass();
      send_idle_pct = 22;
      recv_idle_pct = 56;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_unknown_index();
      test_top_of_range();
      test_radius_zero_windows();
      test_first_minimum_ties();
      test_backpressure();
      test_random_passes(22, 56, RANDOM_ITEMS / 3);
      test_random_passes(56, 22, RANDOM_ITEMS / 3);
      test_random_passes(0, 0, RANDOM_ITEMS / 3);

      $display("Covered %0d samples, %0d results and %0d register writes,", samples_sent,
               results_seen, reg_writes);
      $display("with empty, top-of-range and held-off cases plus three idle mixes.");
      if (errors == 0) begin
         $display("loop_point_boundary_search verification clean");
      end else begin
         $display("loop_point_boundary_search verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(3_000_000);
      $display("loop_point_boundary_search verification failed");
      $finish;
   end

endmodule
